// ===== design/lkvc_pkg.sv =====
package lkvc_pkg;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam int DATA_W = 32;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic capture;
    logic compare;
    logic select;
    logic update;
  } lkvc_cmd_t;

  typedef struct packed {
    logic out_free;
  } lkvc_stat_t;

endpackage

// ===== design/lkvc_ram.sv =====
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/lkvc_ctrl.sv =====
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lkvc_stat_t stat,
  output lkvc_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_SEL  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_next = ST_SEL;
      end
      ST_SEL: begin
        cmd.select = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (stat.out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/lkvc_datapath.sv =====
module lkvc_datapath
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  lkvc_cmd_t         cmd,
  output lkvc_stat_t        stat,
  input  logic [CAP_W-1:0]  capacity,
  input  logic              in_op,
  input  logic [DATA_W-1:0] in_key,
  input  logic [DATA_W-1:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [DATA_W-1:0] out_value
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [IDX_W:0] THR_ALL = (IDX_W + 1)'(ENTRIES);
  localparam logic [CMP_W-1:0] CAP_MAX = CMP_W'(ENTRIES);

  logic [DATA_W-1:0] keys [ENTRIES];
  logic [IDX_W-1:0]  ranks [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]  count;

  logic              op_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] wval_r;

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] lru_vec;
  logic [ENTRIES-1:0] free_vec;
  logic               room;

  logic               hit_r;
  logic               insert_r;
  logic               rank_en;
  logic               key_we;
  logic [ENTRIES-1:0] slot_vec;
  logic [IDX_W-1:0]   slot_idx;
  logic [IDX_W:0]     thr;

  logic [CNT_W-1:0]   cnt_m1;
  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   cap_eff;
  logic [ENTRIES-1:0] free_low;
  logic [ENTRIES-1:0] sel_vec;
  logic [IDX_W-1:0]   sel_idx;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W:0]     sel_thr;
  logic               sel_hit;
  logic               sel_insert;
  logic [DATA_W-1:0]  ram_rdata;

  assign cnt_m1  = count - CNT_W'(1);
  assign cap_ext = CMP_W'(capacity);

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = cap_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      key_r  <= in_key;
      wval_r <= in_value;
    end
  end

  // parallel key compare and lru / free search
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < ENTRIES; i++) begin
        hit_vec[i]  <= valid[i] && (keys[i] == key_r);
        lru_vec[i]  <= valid[i] && (ranks[i] == cnt_m1[IDX_W-1:0]);
        free_vec[i] <= !valid[i];
      end
      room <= CMP_W'(count) < cap_eff;
    end
  end

  assign free_low   = free_vec & (~free_vec + ENTRIES'(1));
  assign sel_hit    = |hit_vec;
  assign sel_insert = !sel_hit && room && (|free_vec);

  always_comb begin
    hit_idx = '0;
    sel_idx = '0;
    sel_thr = '0;
    if (sel_hit) begin
      sel_vec = hit_vec;
    end else if (sel_insert) begin
      sel_vec = free_low;
    end else begin
      sel_vec = lru_vec;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (sel_vec[i]) begin
        sel_idx = sel_idx | IDX_W'(i);
        sel_thr = sel_thr | {1'b0, ranks[i]};
      end
    end
    if (sel_insert) begin
      sel_thr = THR_ALL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      hit_r    <= sel_hit;
      insert_r <= sel_insert;
      rank_en  <= sel_hit || (op_r == OP_PUT);
      key_we   <= !sel_hit && (op_r == OP_PUT);
      slot_vec <= sel_vec;
      slot_idx <= sel_idx;
      thr      <= sel_thr;
    end
  end

  lkvc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_values (
    .clk   (clk),
    .we    (cmd.update && (op_r == OP_PUT)),
    .waddr (slot_idx),
    .wdata (wval_r),
    .re    (cmd.select),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd.update && key_we && slot_vec[i]) begin
        keys[i] <= key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else if (cmd.update && rank_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_vec[i]) begin
          ranks[i] <= '0;
        end else if (valid[i] && ({1'b0, ranks[i]} < thr)) begin
          ranks[i] <= ranks[i] + IDX_W'(1);
        end
      end
      if (insert_r) begin
        valid <= valid | slot_vec;
        count <= count + CNT_W'(1);
      end
    end
  end

  // result register
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_found <= hit_r;
      if (op_r == OP_PUT) begin
        out_value <= '0;
      end else if (hit_r) begin
        out_value <= ram_rdata;
      end else begin
        out_value <= '1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(count))
    else $error("entry count differs from valid slots");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.select |-> $onehot0(hit_vec))
    else $error("key stored in more than one slot");

  a_one_slot_updated: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && rank_en) |-> $onehot(slot_vec))
    else $error("update without exactly one target slot");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= ENTRIES)
    else $error("entry count above slot count");
`endif

endmodule

// ===== design/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement over
// ENTRIES slots, of which at most cfg capacity (0 acts as 1, above ENTRIES acts
// as ENTRIES) are filled before the least recent entry is replaced. Each
// transaction passes through the four-step sequencer: accept, parallel key
// compare, slot select with value memory read, then value/rank update. The
// result enters the output register at the end of the update step, and the
// next transaction is accepted in the cycle after that. One result per
// transaction; a get miss returns found 0 and value -1, a put returns value 0.
// A new transaction is accepted while the previous result waits; the update
// step holds until the output register is free. No clearing pass after reset.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,     // capacity_in_use
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [63:0]      s_axis_tdata,  // lookup_key, write_value
  input  logic             s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // read_value
  output logic             m_axis_tuser   // found
);

  logic [CAP_W-1:0] capacity;
  lkvc_cmd_t        cmd;
  lkvc_stat_t       stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .capacity  (capacity),
    .in_op     (s_axis_tuser),
    .in_key    (s_axis_tdata[31:0]),
    .in_value  (s_axis_tdata[63:32]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_found (m_axis_tuser),
    .out_value (m_axis_tdata)
  );

endmodule

// ===== sim/lru_key_value_cache_tb.sv =====
`timescale 1ns / 100ps

module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  localparam int ENTRIES = 16;
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE = '0;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 151;

  typedef struct packed {
    logic found;
    logic [DATA_W-1:0] value;
  } cache_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic s_axis_tuser = OP_GET;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tuser;

  // cache image tracked alongside the block
  logic [DATA_W-1:0] slot_key [ENTRIES];
  logic [DATA_W-1:0] slot_val [ENTRIES];
  bit slot_live [ENTRIES];
  int unsigned slot_rank [ENTRIES];
  int unsigned fill_count = 0;
  logic [CAP_W-1:0] capacity_reg = CAP_RESET;

  cache_reply_t cache_replies_due [$];
  int error_count = 0;

  int gap_max = 0;
  int burst_left = 0;
  int stall_pct = 0;
  int rx_holdoff = 0;

  lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #10 clk = ~clk;

  function automatic int unsigned capacity_limit();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > ENTRIES) return ENTRIES;
    return 32'(capacity_reg);
  endfunction

  function automatic void promote_slot(input int s);
    int unsigned r;
    r = slot_rank[s];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_live[i] && slot_rank[i] < r) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  function automatic void predict_cache_access(input logic op, input logic [DATA_W-1:0] key,
                                               input logic [DATA_W-1:0] val);
    int hit;
    int spare;
    int oldest;
    bit any;
    cache_reply_t r;
    hit = -1;
    spare = -1;
    oldest = 0;
    any = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;
    if (op == OP_GET) begin
      if (hit >= 0) begin
        promote_slot(hit);
        r = '{found: 1'b1, value: slot_val[hit]};
      end else begin
        r = '{found: 1'b0, value: MISS_VALUE};
      end
    end else if (hit >= 0) begin
      slot_val[hit] = val;
      promote_slot(hit);
      r = '{found: 1'b1, value: PUT_VALUE};
    end else begin
      r = '{found: 1'b0, value: PUT_VALUE};
      if (fill_count < capacity_limit())
        for (int i = 0; i < ENTRIES; i++)
          if (spare < 0 && !slot_live[i]) spare = i;
      if (spare >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i]) slot_rank[i]++;
        slot_live[spare] = 1;
        slot_key[spare] = key;
        slot_val[spare] = val;
        slot_rank[spare] = 0;
        fill_count++;
      end else begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i] && (!any || slot_rank[i] > slot_rank[oldest])) begin
            any = 1;
            oldest = i;
          end
        slot_key[oldest] = key;
        slot_val[oldest] = val;
        promote_slot(oldest);
      end
    end
    cache_replies_due.push_back(r);
  endfunction

  task automatic send_request(input logic op, input logic [DATA_W-1:0] key,
                              input logic [DATA_W-1:0] val);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {val, key};
    s_axis_tuser <= op;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    predict_cache_access(op, key, val);
    if (burst_left > 0) begin
      burst_left--;
    end else if (gap_max > 0) begin
      gap = $urandom_range(1, gap_max);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    s_axis_tvalid <= 1'b0;
    while (cache_replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_reg = cap;
  endtask

  task automatic note_mismatch(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    error_count++;
    if (error_count <= 10)
      $display("mismatch at %0t: %s expected %h got %h", $realtime, field, want, got);
  endtask

  // result checker
  always @(posedge clk) begin
    cache_reply_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (cache_replies_due.size() == 0) begin
        note_mismatch("transaction with none pending, read_value", '0, m_axis_tdata);
      end else begin
        want = cache_replies_due.pop_front();
        if (m_axis_tuser !== want.found)
          note_mismatch("found", DATA_W'(want.found), DATA_W'(m_axis_tuser));
        if (m_axis_tdata !== want.value) note_mismatch("read_value", want.value, m_axis_tdata);
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (rx_holdoff > 0) begin
      rx_holdoff = rx_holdoff - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic test_directed_access();
    gap_max = 3;
    stall_pct = 30;
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0001, 32'hDEAD_BEEF);
  endtask

  task automatic test_directed_capacity();
    // zero acts as one, and four entries already held
    set_capacity(5'd0);
    send_request(OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h5555_5555, 32'h0000_0000);
    // above the slot count acts as full size
    set_capacity(5'd31);
    send_request(OP_PUT, 32'h0000_0002, 32'h0000_0022);
    send_request(OP_PUT, 32'h0000_0003, 32'h0000_0033);
    send_request(OP_GET, 32'h0000_0002, 32'h0000_0000);
    set_capacity(5'd1);
    send_request(OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(OP_GET, 32'h5555_5555, 32'h0000_0000);
    send_request(OP_GET, 32'hAAAA_AAAA, 32'h0000_0000);
  endtask

  task automatic test_output_holdoff();
    set_capacity(5'd16);
    gap_max = 0;
    stall_pct = 0;
    rx_holdoff = 300;
    for (int n = 0; n < 40; n++)
      send_request($urandom_range(0, 1) ? OP_PUT : OP_GET, $urandom_range(0, 20), $urandom);
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] phase_caps [RANDOM_PHASES] =
      '{5'd16, 5'd1, 5'd0, 5'd3, 5'd31, 5'd8, 5'd17, 5'd2, 5'd16, 5'd5};
    logic [DATA_W-1:0] corner_keys [4] =
      '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    int pace_choice [3] = '{0, 3, 10};
    int stall_choice [3] = '{0, 30, 70};
    logic [DATA_W-1:0] key_pool [$];
    logic [DATA_W-1:0] key;
    int pool_size;
    int sel;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_capacity(phase_caps[p]);
      gap_max = pace_choice[$urandom_range(0, 2)];
      stall_pct = stall_choice[$urandom_range(0, 2)];
      burst_left = 0;
      key_pool.delete();
      pool_size = $urandom_range(1, capacity_limit() + 6);
      for (int k = 0; k < pool_size; k++) key_pool.push_back($urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 85) key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (sel < 95) key = $urandom;
        else key = corner_keys[$urandom_range(0, 3)];
        send_request($urandom_range(0, 1) ? OP_PUT : OP_GET, key, $urandom);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_access();
    test_directed_capacity();
    test_output_holdoff();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (cache_replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
